// File: rtl/c8_pkg.sv
// c8_pkg: shared types, codes and constants of the CHIP-8 instruction step core.
// Used by c8_ctrl, c8_dpath and chip8_cpu_step; depends on nothing.
package c8_pkg;

	localparam int MEM_DEPTH = 4096;
	localparam int MA_W      = 12;
	localparam int SCREEN_W  = 64;
	localparam int SCREEN_H  = 32;
	localparam int FONT_LEN  = 80;

	localparam logic [11:0] PC_RESET   = 12'd512;
	localparam logic [7:0]  TICK_RESET = 8'd8;

	localparam logic [1:0] RS_OK      = 2'd0;
	localparam logic [1:0] RS_NOPROG  = 2'd1;
	localparam logic [1:0] RS_BADOP   = 2'd2;
	localparam logic [1:0] RS_WAITKEY = 2'd3;

	localparam logic CFG_TICK  = 1'b0;
	localparam logic CFG_START = 1'b1;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;
	localparam logic [7:0]  FN_SKP  = 8'h9E;
	localparam logic [7:0]  FN_SKNP = 8'hA1;
	localparam logic [7:0]  FN_GDLY = 8'h07;
	localparam logic [7:0]  FN_KEY  = 8'h0A;
	localparam logic [7:0]  FN_SDLY = 8'h15;
	localparam logic [7:0]  FN_SSND = 8'h18;
	localparam logic [7:0]  FN_ADDI = 8'h1E;
	localparam logic [7:0]  FN_FONT = 8'h29;
	localparam logic [7:0]  FN_BCD  = 8'h33;
	localparam logic [7:0]  FN_STR  = 8'h55;
	localparam logic [7:0]  FN_LDR  = 8'h65;

	localparam logic [7:0] FONT [FONT_LEN] = '{
		8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
		8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
		8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
		8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
		8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
		8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
		8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
		8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
	};

	typedef enum logic [1:0] {
		REQ_WR   = 2'd0,
		REQ_EXEC = 2'd1,
		REQ_ROW  = 2'd2,
		REQ_MEM  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		OC_BASIC,
		OC_FLAG,
		OC_DRAW,
		OC_BCD,
		OC_STORE,
		OC_LOAD
	} opclass_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISP,
		ST_MRD,
		ST_F1,
		ST_F2,
		ST_VRD,
		ST_EXEC,
		ST_VF,
		ST_DRD,
		ST_DWR,
		ST_BCD,
		ST_STRD,
		ST_STWR,
		ST_LDRD,
		ST_LDWR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic take;
		logic clr_step;
		logic mem_wr_req;
		logic mem_rd_req;
		logic rd_mem_cap;
		logic row_cap;
		logic noprog;
		logic fetch_hi;
		logic fetch_lo;
		logic op_cap;
		logic vrd;
		logic exec;
		logic vf_wr;
		logic draw_rd;
		logic draw_wr;
		logic bcd_wr;
		logic st_rd;
		logic st_wr;
		logic ld_rd;
		logic ld_wr;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic     clr_done;
		logic     loaded;
		req_t     req;
		opclass_t opclass;
		logic     draw_empty;
		logic     loop_last;
	} stat_t;

endpackage

// File: rtl/c8_ctrl.sv
// c8_ctrl: sequencer of the CHIP-8 step core; issues datapath commands per state.
// Depends on c8_pkg.
module c8_ctrl import c8_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   fin_ok;

	assign fin_ok    = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (stat.clr_done) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_DISP;
			ST_DISP: begin
				unique case (stat.req)
					REQ_WR, REQ_ROW: state_d = ST_FIN;
					REQ_MEM:         state_d = ST_MRD;
					REQ_EXEC:        state_d = stat.loaded ? ST_F1 : ST_FIN;
				endcase
			end
			ST_MRD: state_d = ST_FIN;
			ST_F1:  state_d = ST_F2;
			ST_F2:  state_d = ST_VRD;
			ST_VRD: state_d = ST_EXEC;
			ST_EXEC: begin
				unique case (stat.opclass)
					OC_BASIC: state_d = ST_FIN;
					OC_FLAG:  state_d = ST_VF;
					OC_DRAW:  state_d = stat.draw_empty ? ST_VF : ST_DRD;
					OC_BCD:   state_d = ST_BCD;
					OC_STORE: state_d = ST_STRD;
					OC_LOAD:  state_d = ST_LDRD;
					default:  state_d = ST_FIN;
				endcase
			end
			ST_VF:   state_d = ST_FIN;
			ST_DRD:  state_d = ST_DWR;
			ST_DWR:  state_d = stat.loop_last ? ST_VF : ST_DRD;
			ST_BCD:  if (stat.loop_last) state_d = ST_FIN;
			ST_STRD: state_d = ST_STWR;
			ST_STWR: state_d = stat.loop_last ? ST_FIN : ST_STRD;
			ST_LDRD: state_d = ST_LDWR;
			ST_LDWR: state_d = stat.loop_last ? ST_FIN : ST_LDRD;
			ST_FIN:  if (fin_ok) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE:  cmd.take = in_valid;
			ST_DISP: begin
				unique case (stat.req)
					REQ_WR:   cmd.mem_wr_req = 1'b1;
					REQ_ROW:  cmd.row_cap = 1'b1;
					REQ_MEM:  cmd.mem_rd_req = 1'b1;
					REQ_EXEC: begin
						cmd.fetch_hi = stat.loaded;
						cmd.noprog   = !stat.loaded;
					end
				endcase
			end
			ST_MRD:  cmd.rd_mem_cap = 1'b1;
			ST_F1:   cmd.fetch_lo = 1'b1;
			ST_F2:   cmd.op_cap = 1'b1;
			ST_VRD:  cmd.vrd = 1'b1;
			ST_EXEC: cmd.exec = 1'b1;
			ST_VF:   cmd.vf_wr = 1'b1;
			ST_DRD:  cmd.draw_rd = 1'b1;
			ST_DWR:  cmd.draw_wr = 1'b1;
			ST_BCD:  cmd.bcd_wr = 1'b1;
			ST_STRD: cmd.st_rd = 1'b1;
			ST_STWR: cmd.st_wr = 1'b1;
			ST_LDRD: cmd.ld_rd = 1'b1;
			ST_LDWR: cmd.ld_wr = 1'b1;
			ST_FIN:  cmd.fin = fin_ok;
			default: cmd = '0;
		endcase
	end

endmodule

// File: rtl/c8_dpath.sv
// c8_dpath: registers, program memory, screen, stack and execute logic of the core.
// Depends on c8_pkg; driven by c8_ctrl commands.
module c8_dpath import c8_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic [1:0]  req_type,
	input  logic [11:0] address,
	input  logic [7:0]  data_byte,
	input  logic        key_valid,
	input  logic [3:0]  key_code,
	input  logic [7:0]  random_byte,
	output logic [1:0]  status,
	output logic [11:0] pc,
	output logic [15:0] opcode,
	output logic [63:0] read_data,
	output logic        screen_changed,
	output logic        sound_on
);

	localparam int SP_W = $clog2(STACK_DEPTH);

	// captured item
	logic [1:0]  req_q;
	logic [11:0] addr_q;
	logic [7:0]  dbyte_q, rnd_q;
	logic        kvalid_q;
	logic [3:0]  kcode_q;

	// architectural state
	logic [11:0] pc_q;
	logic [15:0] idx_q;
	logic [SP_W-1:0] sp_q;
	logic [7:0]  delay_q, sound_q, tdiv_q, ipt_q;
	logic        loaded_q;
	logic [63:0] scr_q [SCREEN_H];

	// step registers
	logic [MA_W-1:0] clr_q;
	logic [7:0]  hi_q;
	logic [15:0] op_q;
	logic [3:0]  cnt_q;
	logic        flag_q, ran_q, chg_q;
	logic [1:0]  st_q;
	logic [63:0] rdata_q;

	// output registers
	logic [1:0]  o_status_q;
	logic [11:0] o_pc_q;
	logic [15:0] o_op_q;
	logic [63:0] o_rdata_q;
	logic        o_chg_q, o_snd_q;

	// memories
	logic [7:0]  mem [MEM_DEPTH];
	logic [7:0]  mem_q;
	logic [7:0]  vmem [16];
	logic [15:0] vok_q;
	logic [7:0]  va_q, vb_q;
	logic        vok_a_q, vok_b_q;
	logic [11:0] stk [STACK_DEPTH];
	logic [11:0] stk_q;

	logic [3:0]  x, y, n;
	logic [7:0]  nn, vx, vy;
	logic [11:0] nnn;
	logic [16:0] idx_k;
	logic [MA_W-1:0] ma_k, mem_ra, mem_wa;
	logic        mem_we;
	logic [7:0]  mem_wd;
	logic [3:0]  va_ra, vb_ra, v_wa;
	logic        v_we;
	logic [7:0]  v_wd;
	logic [SP_W-1:0] sp_inc, sp_dec;

	// execute results
	logic [11:0] npc;
	logic        ex_vwe, ex_flag, ex_bad, ex_wait, ex_clr, ex_chg, ex_push, ex_pop;
	logic [7:0]  ex_vwd;
	logic        ex_idx_we, ex_dly_we, ex_snd_we;
	logic [15:0] ex_idx;
	logic [8:0]  alu_sum;
	logic        key_hit;
	opclass_t    oc;

	// draw
	logic [4:0]   ry;
	logic [63:0]  row, spr;
	logic [127:0] spr2;

	// bcd
	logic [1:0]  bh;
	logic [6:0]  brem;
	logic [14:0] bprod;
	logic [3:0]  bt, bo;
	logic [7:0]  bdig;
	logic [3:0]  lim;

	// timers
	logic [7:0]  t1, dly_t, snd_t;
	logic        tk;

	assign x   = op_q[11:8];
	assign y   = op_q[7:4];
	assign n   = op_q[3:0];
	assign nn  = op_q[7:0];
	assign nnn = op_q[11:0];
	assign vx  = vok_a_q ? va_q : 8'd0;
	assign vy  = vok_b_q ? vb_q : 8'd0;

	assign idx_k = {1'b0, idx_q} + 17'(cnt_q);
	assign ma_k  = idx_k[MA_W-1:0];

	assign sp_inc = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	assign sp_dec = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - 1'b1;

	// program memory ports
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ma_k;
		mem_wd = 8'd0;
		if (cmd.clr_step) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = (clr_q < MA_W'(FONT_LEN)) ? FONT[clr_q[6:0]] : 8'd0;
		end else if (cmd.mem_wr_req) begin
			mem_we = 1'b1;
			mem_wa = addr_q;
			mem_wd = dbyte_q;
		end else if (cmd.bcd_wr) begin
			mem_we = 1'b1;
			mem_wd = bdig;
		end else if (cmd.st_wr) begin
			mem_we = 1'b1;
			mem_wd = vx;
		end
	end

	always_comb begin
		mem_ra = ma_k;
		if (cmd.mem_rd_req)
			mem_ra = addr_q;
		else if (cmd.fetch_hi)
			mem_ra = pc_q;
		else if (cmd.fetch_lo)
			mem_ra = pc_q + 12'd1;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		mem_q <= mem[mem_ra];
	end

	// V register file, valid bits stand for the all-zero reset
	assign va_ra = cmd.st_rd ? cnt_q : x;
	assign vb_ra = (op_q[15:12] == 4'hB) ? 4'd0 : y;

	always_comb begin
		v_we = 1'b0;
		v_wa = x;
		v_wd = ex_vwd;
		if (cmd.ld_wr) begin
			v_we = 1'b1;
			v_wa = cnt_q;
			v_wd = mem_q;
		end else if (cmd.vf_wr) begin
			v_we = 1'b1;
			v_wa = 4'hF;
			v_wd = {7'd0, flag_q};
		end else if (cmd.exec) begin
			v_we = ex_vwe;
		end
	end

	always_ff @(posedge clk) begin
		if (v_we)
			vmem[v_wa] <= v_wd;
		if (cmd.vrd || cmd.st_rd)
			va_q <= vmem[va_ra];
		if (cmd.vrd)
			vb_q <= vmem[vb_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vok_q   <= '0;
			vok_a_q <= 1'b0;
			vok_b_q <= 1'b0;
		end else begin
			if (v_we)
				vok_q[v_wa] <= 1'b1;
			if (cmd.vrd || cmd.st_rd)
				vok_a_q <= vok_q[va_ra];
			if (cmd.vrd)
				vok_b_q <= vok_q[vb_ra];
		end
	end

	// return stack
	always_ff @(posedge clk) begin
		if (cmd.exec && ex_push)
			stk[sp_inc] <= pc_q + 12'd2;
		if (cmd.vrd)
			stk_q <= stk[sp_q];
	end

	// execute decode
	assign alu_sum = {1'b0, vx} + {1'b0, vy};
	assign key_hit = kvalid_q && (vx[7:4] == 4'd0) && (vx[3:0] == kcode_q);

	always_comb begin
		npc       = pc_q + 12'd2;
		ex_vwe    = 1'b0;
		ex_vwd    = 8'd0;
		ex_flag   = 1'b0;
		ex_bad    = 1'b0;
		ex_wait   = 1'b0;
		ex_clr    = 1'b0;
		ex_chg    = 1'b0;
		ex_push   = 1'b0;
		ex_pop    = 1'b0;
		ex_idx_we = 1'b0;
		ex_idx    = idx_q;
		ex_dly_we = 1'b0;
		ex_snd_we = 1'b0;
		oc        = OC_BASIC;
		unique case (op_q[15:12])
			4'h0: begin
				if (op_q == OP_CLS) begin
					ex_clr = 1'b1;
					ex_chg = 1'b1;
				end else if (op_q == OP_RET) begin
					npc    = stk_q;
					ex_pop = 1'b1;
				end else begin
					ex_bad = 1'b1;
				end
			end
			4'h1: npc = nnn;
			4'h2: begin
				ex_push = 1'b1;
				npc     = nnn;
			end
			4'h3: if (vx == nn) npc = pc_q + 12'd4;
			4'h4: if (vx != nn) npc = pc_q + 12'd4;
			4'h5: if (vx == vy) npc = pc_q + 12'd4;
			4'h6: begin
				ex_vwe = 1'b1;
				ex_vwd = nn;
			end
			4'h7: begin
				ex_vwe = 1'b1;
				ex_vwd = vx + nn;
			end
			4'h8: begin
				ex_vwe = 1'b1;
				case (n)
					4'h0: ex_vwd = vy;
					4'h1: ex_vwd = vx | vy;
					4'h2: ex_vwd = vx & vy;
					4'h3: ex_vwd = vx ^ vy;
					4'h4: begin
						ex_vwd  = alu_sum[7:0];
						ex_flag = alu_sum[8];
						oc      = OC_FLAG;
					end
					4'h5: begin
						ex_vwd  = vx - vy;
						ex_flag = (vx >= vy);
						oc      = OC_FLAG;
					end
					4'h6: begin
						ex_vwd  = {1'b0, vx[7:1]};
						ex_flag = vx[0];
						oc      = OC_FLAG;
					end
					4'h7: begin
						ex_vwd  = vy - vx;
						ex_flag = (vy >= vx);
						oc      = OC_FLAG;
					end
					4'hE: begin
						ex_vwd  = {vx[6:0], 1'b0};
						ex_flag = vx[7];
						oc      = OC_FLAG;
					end
					default: begin
						ex_vwe = 1'b0;
						ex_bad = 1'b1;
					end
				endcase
			end
			4'h9: if (vx != vy) npc = pc_q + 12'd4;
			4'hA: begin
				ex_idx_we = 1'b1;
				ex_idx    = {4'd0, nnn};
			end
			4'hB: npc = nnn + {4'd0, vy};
			4'hC: begin
				ex_vwe = 1'b1;
				ex_vwd = rnd_q & nn;
			end
			4'hD: begin
				ex_chg = 1'b1;
				oc     = OC_DRAW;
			end
			4'hE: begin
				if (nn == FN_SKP) begin
					if (key_hit) npc = pc_q + 12'd4;
				end else if (nn == FN_SKNP) begin
					if (!key_hit) npc = pc_q + 12'd4;
				end else begin
					ex_bad = 1'b1;
				end
			end
			4'hF: begin
				unique case (nn)
					FN_GDLY: begin
						ex_vwe = 1'b1;
						ex_vwd = delay_q;
					end
					FN_KEY: begin
						if (kvalid_q) begin
							ex_vwe = 1'b1;
							ex_vwd = {4'd0, kcode_q};
						end else begin
							ex_wait = 1'b1;
							npc     = pc_q;
						end
					end
					FN_SDLY: ex_dly_we = 1'b1;
					FN_SSND: ex_snd_we = 1'b1;
					FN_ADDI: begin
						ex_idx_we = 1'b1;
						ex_idx    = idx_q + {8'd0, vx};
					end
					FN_FONT: begin
						ex_idx_we = 1'b1;
						ex_idx    = {10'd0, vx[3:0], 2'b00} + {12'd0, vx[3:0]};
					end
					FN_BCD: oc = OC_BCD;
					FN_STR: oc = OC_STORE;
					FN_LDR: oc = OC_LOAD;
					default: ex_bad = 1'b1;
				endcase
			end
		endcase
	end

	// sprite row
	assign ry   = vy[4:0] + {1'b0, cnt_q};
	assign row  = scr_q[cmd.draw_wr ? ry : addr_q[4:0]];
	assign spr2 = {mem_q, 56'd0, mem_q, 56'd0} >> vx[5:0];
	assign spr  = spr2[63:0];

	// decimal digits
	assign bh    = (vx >= 8'd200) ? 2'd2 : ((vx >= 8'd100) ? 2'd1 : 2'd0);
	assign brem  = 7'(vx - 8'(bh) * 8'd100);
	assign bprod = 15'(brem) * 15'd205;
	assign bt    = bprod[14:11];
	assign bo    = 4'(brem - 7'(bt) * 7'd10);
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    bdig = {6'd0, bh};
			2'd1:    bdig = {4'd0, bt};
			default: bdig = {4'd0, bo};
		endcase
	end

	always_comb begin
		case (oc)
			OC_DRAW: lim = n - 4'd1;
			OC_BCD:  lim = 4'd2;
			default: lim = x;
		endcase
	end

	// timers after the instruction
	assign t1    = tdiv_q + 8'd1;
	assign tk    = ran_q && (t1 >= ipt_q);
	assign dly_t = (tk && delay_q != 8'd0) ? delay_q - 8'd1 : delay_q;
	assign snd_t = (tk && sound_q != 8'd0) ? sound_q - 8'd1 : sound_q;

	assign stat.clr_done   = (clr_q == MA_W'(MEM_DEPTH - 1));
	assign stat.loaded     = loaded_q;
	assign stat.req        = req_t'(req_q);
	assign stat.opclass    = oc;
	assign stat.draw_empty = (n == 4'd0);
	assign stat.loop_last  = (cnt_q == lim);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q    <= req_type;
			addr_q   <= address;
			dbyte_q  <= data_byte;
			kvalid_q <= key_valid;
			kcode_q  <= key_code;
			rnd_q    <= random_byte;
		end
		if (cmd.fetch_lo)
			hi_q <= mem_q;
		if (cmd.op_cap)
			op_q <= {hi_q, mem_q};
		if (cmd.fin) begin
			o_status_q <= st_q;
			o_pc_q     <= pc_q;
			o_op_q     <= ran_q ? op_q : 16'd0;
			o_rdata_q  <= rdata_q;
			o_chg_q    <= chg_q;
			o_snd_q    <= (snd_t != 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			pc_q     <= PC_RESET;
			ipt_q    <= TICK_RESET;
			idx_q    <= 16'd0;
			sp_q     <= '0;
			delay_q  <= 8'd0;
			sound_q  <= 8'd0;
			tdiv_q   <= 8'd0;
			loaded_q <= 1'b0;
			cnt_q    <= 4'd0;
			flag_q   <= 1'b0;
			ran_q    <= 1'b0;
			chg_q    <= 1'b0;
			st_q     <= RS_OK;
			rdata_q  <= 64'd0;
			for (int i = 0; i < SCREEN_H; i++)
				scr_q[i] <= 64'd0;
		end else begin
			if (cmd.clr_step)
				clr_q <= clr_q + 1'b1;
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_TICK:  ipt_q <= cfg_data[7:0];
					CFG_START: pc_q <= cfg_data;
					default:   ipt_q <= ipt_q;
				endcase
			end
			if (cmd.take) begin
				ran_q   <= 1'b0;
				chg_q   <= 1'b0;
				st_q    <= RS_OK;
				rdata_q <= 64'd0;
			end
			if (cmd.mem_wr_req)
				loaded_q <= 1'b1;
			if (cmd.row_cap)
				rdata_q <= row;
			if (cmd.rd_mem_cap)
				rdata_q <= {56'd0, mem_q};
			if (cmd.noprog)
				st_q <= RS_NOPROG;
			if (cmd.exec) begin
				ran_q  <= 1'b1;
				chg_q  <= ex_chg;
				cnt_q  <= 4'd0;
				flag_q <= ex_flag;
				pc_q   <= npc;
				if (ex_bad)
					st_q <= RS_BADOP;
				else if (ex_wait)
					st_q <= RS_WAITKEY;
				if (ex_push)
					sp_q <= sp_inc;
				else if (ex_pop)
					sp_q <= sp_dec;
				if (ex_idx_we)
					idx_q <= ex_idx;
				if (ex_dly_we)
					delay_q <= vx;
				if (ex_snd_we)
					sound_q <= vx;
				if (ex_clr)
					for (int i = 0; i < SCREEN_H; i++)
						scr_q[i] <= 64'd0;
			end
			if (cmd.draw_wr) begin
				scr_q[ry] <= row ^ spr;
				if ((row & spr) != 64'd0)
					flag_q <= 1'b1;
			end
			if (cmd.draw_wr || cmd.bcd_wr || cmd.st_wr || cmd.ld_wr)
				cnt_q <= cnt_q + 4'd1;
			if (cmd.fin && ran_q) begin
				delay_q <= dly_t;
				sound_q <= snd_t;
				tdiv_q  <= tk ? 8'd0 : t1;
			end
		end
	end

	assign status         = o_status_q;
	assign pc             = o_pc_q;
	assign opcode         = o_op_q;
	assign read_data      = o_rdata_q;
	assign screen_changed = o_chg_q;
	assign sound_on       = o_snd_q;

endmodule

// File: rtl/chip8_cpu_step.sv
// chip8_cpu_step: CHIP-8 core, one request item in, one result item out.
// Memory write, row read and unloaded execute go straight to finish; memory read
// reads first. Execute fetches, reads V and executes; DXYN, FX33, FX55/FX65 and flag
// ALU ops add loop or VF states. One item at a time through the sequencer and memory.
// After reset, the core fills program memory (font then zeros) before the first item.
// Depends on c8_pkg, c8_ctrl, c8_dpath.
module chip8_cpu_step import c8_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [11:0] address,
	input  logic [7:0]  data_byte,
	input  logic        key_valid,
	input  logic [3:0]  key_code,
	input  logic [7:0]  random_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [11:0] pc,
	output logic [15:0] opcode,
	output logic [63:0] read_data,
	output logic        screen_changed,
	output logic        sound_on
);

	cmd_t  cmd;
	stat_t stat;

	c8_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	c8_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.address        (address),
		.data_byte      (data_byte),
		.key_valid      (key_valid),
		.key_code       (key_code),
		.random_byte    (random_byte),
		.status         (status),
		.pc             (pc),
		.opcode         (opcode),
		.read_data      (read_data),
		.screen_changed (screen_changed),
		.sound_on       (sound_on)
	);

endmodule
